FILE: hdl/rgb_probes_to_xy_chromaticity_macros.svh
// assertion helpers used by the checker of this block
`ifndef RGB_PROBES_TO_XY_CHROMATICITY_MACROS_SVH
`define RGB_PROBES_TO_XY_CHROMATICITY_MACROS_SVH

// property checked on every rising clock edge outside reset
`define XYC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("xyc check failed");

// implication checked on every rising clock edge outside reset
`define XYC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xyc check failed");

`endif

FILE: hdl/xyc_pkg.sv
package xyc_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int COEF_FRAC_BITS = 30;
	localparam int COEF_BITS = 32;
	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int XYZ_W = PROD_W + 2;
	localparam int SUM_W = XYZ_W + 2;
	localparam int XMAG_W = XYZ_W;
	localparam int LO_W = 33;
	localparam int HI_W = XMAG_W - LO_W;
	localparam int MICRO2_W = 21;
	localparam int NUM_W = XMAG_W + MICRO2_W + 1;
	localparam int DEN_W = SUM_W;
	localparam int QB = 27;
	localparam int DSH_W = DEN_W + QB;
	localparam int OUT_W = 28;
	localparam int NUM_LANES = 4;
	localparam int LANE_STAGES = 6;
	localparam int DIV_STAGES = QB + 1;
	localparam int PIPE_STAGES = LANE_STAGES + DIV_STAGES;

	localparam logic [MICRO2_W-1:0] MICRO2 = MICRO2_W'(2000000);
	localparam logic [QB-1:0] SAT_LIMIT = QB'(100000000);

	localparam logic [127:0] DEC_SCALE = 128'd10000000000000000000;
	localparam logic [127:0] DEC_HALF = 128'd5000000000000000000;

	// matrix magnitudes scaled by 1e19, row by row
	localparam logic [63:0] MAT_MAG [9] = '{
		64'd9382798492772553800, 64'd44514458123613527, 64'd166275235867761950,
		64'd3373688907878367200, 64'd7295215666902655800, 64'd668904574781026000,
		64'd11739508496858876, 64'd37107064020525725, 64'd10915945063122463000
	};
	localparam logic [8:0] MAT_NEG = 9'b010_100_010;

	function automatic logic signed [COEF_BITS-1:0] coef_val(input int k);
		logic [127:0] n;
		logic [127:0] q;
		logic [COEF_BITS-1:0] mag;
		n = ({64'd0, MAT_MAG[k]} << COEF_FRAC_BITS) + DEC_HALF;
		q = n / DEC_SCALE;
		mag = q[COEF_BITS-1:0];
		return MAT_NEG[k] ? -mag : mag;
	endfunction

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] red_probe_r;
		logic signed [SAMPLE_BITS-1:0] red_probe_g;
		logic signed [SAMPLE_BITS-1:0] red_probe_b;
		logic signed [SAMPLE_BITS-1:0] green_probe_r;
		logic signed [SAMPLE_BITS-1:0] green_probe_g;
		logic signed [SAMPLE_BITS-1:0] green_probe_b;
		logic signed [SAMPLE_BITS-1:0] blue_probe_r;
		logic signed [SAMPLE_BITS-1:0] blue_probe_g;
		logic signed [SAMPLE_BITS-1:0] blue_probe_b;
		logic signed [SAMPLE_BITS-1:0] white_probe_r;
		logic signed [SAMPLE_BITS-1:0] white_probe_g;
		logic signed [SAMPLE_BITS-1:0] white_probe_b;
	} probes_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] red_x;
		logic signed [OUT_W-1:0] red_y;
		logic signed [OUT_W-1:0] green_x;
		logic signed [OUT_W-1:0] green_y;
		logic signed [OUT_W-1:0] blue_x;
		logic signed [OUT_W-1:0] blue_y;
		logic signed [OUT_W-1:0] white_x;
		logic signed [OUT_W-1:0] white_y;
		logic result_valid;
		logic white_equal_energy;
	} xy_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic zero;
	} lane_res_t;

endpackage

FILE: hdl/rgb_probes_to_xy_chromaticity.sv
// rgb probes to cie xy chromaticity
//
// input channel (probe_valid / probe_ready / probes): one item holds the
// red, green, blue and white probes, each three signed q8.24 samples.
// output channel (xy_valid / xy_ready / xy): one item holds x and y of each
// probe in signed millionths, rounded half away from zero and saturated at
// +/-100.0, plus result_valid and the white equal-energy flag.
//
// four lanes, one per probe, run the 3x3 matrix, the sum and two pipelined
// restoring dividers (one quotient bit per stage); a merge stage combines
// the zero-sum checks, builds the flag and holds the output register.
// the dividers are fully pipelined, so a new item is taken every cycle
// except while the pipeline holds on a stalled output (see below).
//
// reset clears the stage valid bits and the output valid; data registers
// are not reset. when the receiver stalls, bubbles inside the pipeline keep
// draining and probe_ready stays high until a finished item reaches the
// last stage behind the held output; then the whole pipeline holds.
module rgb_probes_to_xy_chromaticity (
	input logic clk,
	input logic arst_n,
	input logic probe_valid,
	output logic probe_ready,
	input xyc_pkg::probes_t probes,
	output logic xy_valid,
	input logic xy_ready,
	output xyc_pkg::xy_t xy
);
	import xyc_pkg::*;

	logic en;
	logic vld_q [PIPE_STAGES];
	logic signed [SAMPLE_BITS-1:0] smp [NUM_LANES][3];
	lane_res_t [NUM_LANES-1:0] lane_res;

	assign probe_ready = en;

	// per-lane sample routing
	assign smp[0][0] = probes.red_probe_r;
	assign smp[0][1] = probes.red_probe_g;
	assign smp[0][2] = probes.red_probe_b;
	assign smp[1][0] = probes.green_probe_r;
	assign smp[1][1] = probes.green_probe_g;
	assign smp[1][2] = probes.green_probe_b;
	assign smp[2][0] = probes.blue_probe_r;
	assign smp[2][1] = probes.blue_probe_g;
	assign smp[2][2] = probes.blue_probe_b;
	assign smp[3][0] = probes.white_probe_r;
	assign smp[3][1] = probes.white_probe_g;
	assign smp[3][2] = probes.white_probe_b;

	// item valid bits that follow the lane pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_STAGES; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= probe_valid;
			for (int i = 1; i < PIPE_STAGES; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		xyc_lane u_lane (
			.clk(clk),
			.en(en),
			.smp_r(smp[l][0]),
			.smp_g(smp[l][1]),
			.smp_b(smp[l][2]),
			.res(lane_res[l])
		);
	end

	xyc_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.lane_res(lane_res),
		.vld_last(vld_q[PIPE_STAGES-1]),
		.xy_ready(xy_ready),
		.en(en),
		.xy_valid(xy_valid),
		.xy(xy)
	);

endmodule

FILE: hdl/xyc_div.sv
module xyc_div (
	input logic clk,
	input logic en,
	input logic [xyc_pkg::NUM_W-1:0] num,
	input logic [xyc_pkg::DEN_W-1:0] den,
	input logic neg,
	output logic signed [xyc_pkg::OUT_W-1:0] res
);
	import xyc_pkg::*;

	logic [NUM_W-1:0] rem_s [QB];
	logic [DEN_W-1:0] d_s [QB];
	logic [QB-1:0] q_s [QB+1];
	logic sat_s [QB+1];
	logic neg_s [QB+1];
	logic over;
	logic [OUT_W-1:0] mag;

	// quotient would need more than QB bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			d_s[0] <= den;
			q_s[0] <= '0;
			sat_s[0] <= DSH_W'(num) >= (DSH_W'(den) << QB);
			neg_s[0] <= neg;
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int B = QB - 1 - k;
		logic [DSH_W-1:0] dsh;
		logic [DSH_W-1:0] diff;
		logic cmp;
		assign dsh = DSH_W'(d_s[k]) << B;
		assign cmp = DSH_W'(rem_s[k]) >= dsh;
		assign diff = DSH_W'(rem_s[k]) - dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1] <= q_s[k] | (QB'(cmp) << B);
				sat_s[k+1] <= sat_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
		if (k < QB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= cmp ? diff[NUM_W-1:0] : rem_s[k];
					d_s[k+1] <= d_s[k];
				end
			end
		end
	end

	assign over = sat_s[QB] || (q_s[QB] > SAT_LIMIT);
	assign mag = over ? OUT_W'(SAT_LIMIT) : OUT_W'(q_s[QB]);
	assign res = neg_s[QB] ? -mag : mag;

endmodule

FILE: hdl/xyc_lane.sv
module xyc_lane (
	input logic clk,
	input logic en,
	input logic signed [xyc_pkg::SAMPLE_BITS-1:0] smp_r,
	input logic signed [xyc_pkg::SAMPLE_BITS-1:0] smp_g,
	input logic signed [xyc_pkg::SAMPLE_BITS-1:0] smp_b,
	output xyc_pkg::lane_res_t res
);
	import xyc_pkg::*;

	localparam logic signed [COEF_BITS-1:0] COEF [9] = '{
		coef_val(0), coef_val(1), coef_val(2),
		coef_val(3), coef_val(4), coef_val(5),
		coef_val(6), coef_val(7), coef_val(8)
	};

	logic signed [SAMPLE_BITS-1:0] smp [3];
	logic signed [PROD_W-1:0] prod_s1 [9];
	logic signed [XYZ_W-1:0] xyz_s2 [2];
	logic signed [XYZ_W-1:0] z_s2;
	logic signed [XYZ_W-1:0] xyz_s3 [2];
	logic signed [SUM_W-1:0] sum_s3;
	logic [XMAG_W-1:0] xmag_s4 [2];
	logic [SUM_W-1:0] smag_s4;
	logic negx_s4, negy_s4, zero_s4;
	logic [LO_W+MICRO2_W-1:0] lo_s5 [2];
	logic [HI_W+MICRO2_W-1:0] hi_s5 [2];
	logic [SUM_W-1:0] smag_s5;
	logic negx_s5, negy_s5, zero_s5;
	logic [NUM_W-1:0] nx_s6, ny_s6;
	logic [DEN_W-1:0] den_s6;
	logic negx_s6, negy_s6, zero_s6;
	logic zero_dly_q [DIV_STAGES];

	assign smp[0] = smp_r;
	assign smp[1] = smp_g;
	assign smp[2] = smp_b;

	for (genvar j = 0; j < 9; j++) begin : g_mul
		localparam int C = j % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[j] <= PROD_W'(smp[C]) * PROD_W'(COEF[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// matrix rows
			xyz_s2[0] <= XYZ_W'(prod_s1[0]) + XYZ_W'(prod_s1[1]) + XYZ_W'(prod_s1[2]);
			xyz_s2[1] <= XYZ_W'(prod_s1[3]) + XYZ_W'(prod_s1[4]) + XYZ_W'(prod_s1[5]);
			z_s2 <= XYZ_W'(prod_s1[6]) + XYZ_W'(prod_s1[7]) + XYZ_W'(prod_s1[8]);
			// X + Y + Z
			xyz_s3 <= xyz_s2;
			sum_s3 <= SUM_W'(xyz_s2[0]) + SUM_W'(xyz_s2[1]) + SUM_W'(z_s2);
			// magnitudes and quotient signs
			xmag_s4[0] <= xyz_s3[0][XYZ_W-1] ? XMAG_W'(-xyz_s3[0]) : XMAG_W'(xyz_s3[0]);
			xmag_s4[1] <= xyz_s3[1][XYZ_W-1] ? XMAG_W'(-xyz_s3[1]) : XMAG_W'(xyz_s3[1]);
			smag_s4 <= sum_s3[SUM_W-1] ? SUM_W'(-sum_s3) : SUM_W'(sum_s3);
			negx_s4 <= xyz_s3[0][XYZ_W-1] ^ sum_s3[SUM_W-1];
			negy_s4 <= xyz_s3[1][XYZ_W-1] ^ sum_s3[SUM_W-1];
			zero_s4 <= (sum_s3 == '0);
			// 2e6 * |X| in two partial products
			for (int i = 0; i < 2; i++) begin
				lo_s5[i] <= (LO_W+MICRO2_W)'(xmag_s4[i][LO_W-1:0]) * (LO_W+MICRO2_W)'(MICRO2);
				hi_s5[i] <= (HI_W+MICRO2_W)'(xmag_s4[i][XMAG_W-1:LO_W])
					* (HI_W+MICRO2_W)'(MICRO2);
			end
			smag_s5 <= smag_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			zero_s5 <= zero_s4;
			// rounding numerator 2e6|X| + |S| over 2|S|
			nx_s6 <= (NUM_W'(hi_s5[0]) << LO_W) + NUM_W'(lo_s5[0]) + NUM_W'(smag_s5);
			ny_s6 <= (NUM_W'(hi_s5[1]) << LO_W) + NUM_W'(lo_s5[1]) + NUM_W'(smag_s5);
			den_s6 <= smag_s5 << 1;
			negx_s6 <= negx_s5;
			negy_s6 <= negy_s5;
			zero_s6 <= zero_s5;
			zero_dly_q[0] <= zero_s6;
			for (int i = 1; i < DIV_STAGES; i++) begin
				zero_dly_q[i] <= zero_dly_q[i-1];
			end
		end
	end

	xyc_div u_div_x (
		.clk(clk), .en(en), .num(nx_s6), .den(den_s6), .neg(negx_s6), .res(res.x)
	);
	xyc_div u_div_y (
		.clk(clk), .en(en), .num(ny_s6), .den(den_s6), .neg(negy_s6), .res(res.y)
	);

	assign res.zero = zero_dly_q[DIV_STAGES-1];

endmodule

FILE: hdl/xyc_merge.sv
module xyc_merge (
	input logic clk,
	input logic arst_n,
	input xyc_pkg::lane_res_t [xyc_pkg::NUM_LANES-1:0] lane_res,
	input logic vld_last,
	input logic xy_ready,
	output logic en,
	output logic xy_valid,
	output xyc_pkg::xy_t xy
);
	import xyc_pkg::*;

	logic out_valid_q;
	xy_t xy_q;
	xy_t nxt;
	logic ok;

	assign en = !(vld_last && out_valid_q && !xy_ready);

	always_comb begin
		ok = 1'b1;
		for (int i = 0; i < NUM_LANES; i++) begin
			ok = ok && !lane_res[i].zero;
		end
		nxt.red_x = ok ? lane_res[0].x : '0;
		nxt.red_y = ok ? lane_res[0].y : '0;
		nxt.green_x = ok ? lane_res[1].x : '0;
		nxt.green_y = ok ? lane_res[1].y : '0;
		nxt.blue_x = ok ? lane_res[2].x : '0;
		nxt.blue_y = ok ? lane_res[2].y : '0;
		nxt.white_x = ok ? lane_res[3].x : '0;
		nxt.white_y = ok ? lane_res[3].y : '0;
		nxt.result_valid = ok;
		nxt.white_equal_energy = ok && (lane_res[3].x == lane_res[3].y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_last || (out_valid_q && !xy_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_last) begin
			xy_q <= nxt;
		end
	end

	assign xy_valid = out_valid_q;
	assign xy = xy_q;

endmodule

FILE: hdl/xyc_checker.sv
`include "rgb_probes_to_xy_chromaticity_macros.svh"

module xyc_checker (
	input logic clk,
	input logic arst_n,
	input logic probe_ready,
	input logic xy_valid,
	input logic xy_ready,
	input xyc_pkg::xy_t xy
);
	import xyc_pkg::*;

	localparam logic signed [OUT_W-1:0] SAT_POS = OUT_W'(SAT_LIMIT);
	localparam logic signed [OUT_W-1:0] SAT_NEG = -SAT_POS;

	logic coords_zero;
	logic in_range;

	assign coords_zero = xy.red_x == '0 && xy.red_y == '0 && xy.green_x == '0
		&& xy.green_y == '0 && xy.blue_x == '0 && xy.blue_y == '0
		&& xy.white_x == '0 && xy.white_y == '0;

	assign in_range = xy.white_x <= SAT_POS && xy.white_x >= SAT_NEG
		&& xy.red_x <= SAT_POS && xy.red_x >= SAT_NEG;

	// a stalled result holds
	`XYC_ASSERT_IMP(a_out_hold, clk, arst_n, xy_valid && !xy_ready, ##1 (xy_valid && $stable(xy)))

	// an invalid result carries only zeros
	`XYC_ASSERT_IMP(a_invalid_zero, clk, arst_n, xy_valid && !xy.result_valid, coords_zero && !xy.white_equal_energy)

	// flag matches the white coordinates
	`XYC_ASSERT_IMP(a_flag, clk, arst_n, xy_valid, xy.white_equal_energy == (xy.result_valid && xy.white_x == xy.white_y))

	// saturation bound on red_x and white_x
	`XYC_ASSERT_IMP(a_sat, clk, arst_n, xy_valid, in_range)

	// an empty output never blocks the input
	`XYC_ASSERT_IMP(a_ready, clk, arst_n, !xy_valid, probe_ready)

endmodule

bind rgb_probes_to_xy_chromaticity xyc_checker u_xyc_checker (.*);
